// ===== rtl/core/fqkr_pkg.sv =====
// shared types and codes for the job queue with keyed removal
// no dependencies; imported by fqkr_slot_mem and fifo_queue_with_keyed_removal
`default_nettype none

package fqkr_pkg;

  localparam int unsigned HandleW = 16;
  localparam int unsigned PidW    = 22;
  localparam int unsigned KeyW    = 16;
  localparam int unsigned PosW    = 5;
  localparam int unsigned StatW   = 2;
  localparam int unsigned CmdW    = 2;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 64;

  localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdW-1:0] CMD_FRONT  = 2'd1;
  localparam logic [CmdW-1:0] CMD_PID    = 2'd2;
  localparam logic [CmdW-1:0] CMD_KEY    = 2'd3;

  localparam logic [StatW-1:0] STAT_OK        = 2'd0;
  localparam logic [StatW-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [StatW-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [StatW-1:0] STAT_FULL      = 2'd3;

  // one queued job, handle in the lowest bits
  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [PidW-1:0]    pid;
    logic [HandleW-1:0] handle;
  } entry_t;

  // control from the sequencer to the slot store
  typedef struct packed {
    logic we;
    logic by_pid;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/fqkr_slot_mem.sv =====
// slot store of the job queue: one write port, one registered read port,
// and the shared pid/key comparator on the read data; uses fqkr_pkg
`default_nettype none

module fqkr_slot_mem
  import fqkr_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IW    = 4
) (
  input  wire logic           clk_i,
  input  wire mem_ctl_t       ctl_i,
  input  wire logic [IW-1:0]  waddr_i,
  input  wire entry_t         wdata_i,
  input  wire logic [IW-1:0]  raddr_i,
  input  wire entry_t         probe_i,
  output entry_t              rdata_o,
  output logic                hit_o
);

  entry_t slots [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      slots[waddr_i] <= wdata_i;
    end
    rdata_q <= slots[raddr_i];
  end

  assign rdata_o = rdata_q;

  // single comparator, field picked by the command in flight
  assign hit_o = ctl_i.by_pid ? (rdata_q.pid == probe_i.pid)
                              : (rdata_q.key == probe_i.key);

endmodule

`default_nettype wire

// ===== rtl/core/fifo_queue_with_keyed_removal.sv =====
// top level of the ordered job queue with removal by pid or key
// depends on fqkr_pkg and fqkr_slot_mem
//
// Usage: commands enter on the s_axis channel (tuser = command, tdata = job
// fields), one result per command leaves on the m_axis channel (tuser =
// status, tdata = job fields and 1-based position). The queue holds up to
// DEPTH jobs in a slot memory with one write port and one registered read port.
// Flow: the block takes one command at a time and drops s_axis_tready
// until its result is parked in the output register. An insert, or any
// command on an empty queue, goes straight to the finish state, which
// loads the output register. A removal scans the queue slot by slot
// (memory read, then compare) and then closes the gap slot by slot (read,
// write back); remove-front matches the first slot read and closes the gap.
// These loops through the slot memory set the rate.
// Reset empties the queue at once; slot contents need no clearing.
// Stall: a result waits in the output register while m_axis_tready is low;
// the next command is still taken and worked on, and its result waits in
// the sequencer until the output register frees.
`default_nettype none

module fifo_queue_with_keyed_removal
  import fqkr_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // job_handle[15:0], proc_id[37:16], job_key[53:38], zero fill
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  wire logic [CmdW-1:0]     s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // out_handle[15:0], out_pid[37:16], out_key[53:38], position[58:54], zero fill
  output logic [OutDataW-1:0]      m_axis_tdata,
  // status[1:0]
  output logic [StatW-1:0]         m_axis_tuser
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_SH_RD = 3'd3;
  localparam logic [2:0] S_SH_WR = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CmdW-1:0]  cmd_q, cmd_d;
  entry_t           item_q, item_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [StatW-1:0] res_stat_q, res_stat_d;
  entry_t           res_ent_q, res_ent_d;
  logic [PosW-1:0]  res_pos_q, res_pos_d;
  logic             m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;
  logic [StatW-1:0] m_user_q, m_user_d;

  mem_ctl_t         mem_ctl;
  logic [IW-1:0]    waddr;
  entry_t           wdata;
  logic [IW-1:0]    raddr;
  entry_t           rdata;
  logic             cmp_hit;

  entry_t           in_ent;
  logic [CW:0]      idx_inc;
  logic [CW:0]      idx_inc2;
  logic [CW:0]      cnt_ext;
  logic [31:0]      idx_pos;
  logic [31:0]      cnt_pos;
  logic             out_free;

  assign in_ent   = entry_t'(s_axis_tdata[KeyW+PidW+HandleW-1:0]);
  assign idx_inc  = {1'b0, idx_q} + {{CW{1'b0}}, 1'b1};
  assign idx_inc2 = idx_inc + {{CW{1'b0}}, 1'b1};
  assign cnt_ext  = {1'b0, cnt_q};
  assign idx_pos  = 32'(idx_q) + 32'd1;
  assign cnt_pos  = 32'(cnt_q) + 32'd1;
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    item_d     = item_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    res_stat_d = res_stat_q;
    res_ent_d  = res_ent_q;
    res_pos_d  = res_pos_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    m_user_d   = m_user_q;
    s_axis_tready = 1'b0;
    mem_ctl.we     = 1'b0;
    mem_ctl.by_pid = (cmd_q == CMD_PID);
    waddr = idx_q[IW-1:0];
    wdata = rdata;
    raddr = idx_q[IW-1:0];

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_d  = s_axis_tuser;
          item_d = in_ent;
          state_d = S_FIN;
          if (s_axis_tuser == CMD_INSERT) begin
            if (cnt_q == CW'(DEPTH)) begin
              res_stat_d = STAT_FULL;
              res_ent_d  = '0;
              res_pos_d  = '0;
            end else begin
              mem_ctl.we = 1'b1;
              waddr      = cnt_q[IW-1:0];
              wdata      = in_ent;
              cnt_d      = cnt_q + {{(CW-1){1'b0}}, 1'b1};
              res_stat_d = STAT_OK;
              res_ent_d  = in_ent;
              res_pos_d  = cnt_pos[PosW-1:0];
            end
          end else if (cnt_q == '0) begin
            res_stat_d = STAT_EMPTY;
            res_ent_d  = '0;
            res_pos_d  = '0;
          end else begin
            idx_d   = '0;
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (cmd_q == CMD_FRONT || cmp_hit) begin
          res_stat_d = STAT_OK;
          res_ent_d  = rdata;
          res_pos_d  = idx_pos[PosW-1:0];
          if (idx_inc < cnt_ext) begin
            state_d = S_SH_RD;
          end else begin
            cnt_d   = cnt_q - {{(CW-1){1'b0}}, 1'b1};
            state_d = S_FIN;
          end
        end else if (idx_inc == cnt_ext) begin
          res_stat_d = STAT_NOT_FOUND;
          res_ent_d  = '0;
          res_pos_d  = '0;
          state_d    = S_FIN;
        end else begin
          idx_d   = idx_inc[CW-1:0];
          state_d = S_RD;
        end
      end
      S_SH_RD: begin
        raddr   = idx_inc[IW-1:0];
        state_d = S_SH_WR;
      end
      S_SH_WR: begin
        // move the later slot one place forward
        mem_ctl.we = 1'b1;
        waddr      = idx_q[IW-1:0];
        wdata      = rdata;
        idx_d      = idx_inc[CW-1:0];
        if (idx_inc2 < cnt_ext) begin
          state_d = S_SH_RD;
        end else begin
          cnt_d   = cnt_q - {{(CW-1){1'b0}}, 1'b1};
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_user_d  = res_stat_q;
          m_data_d  = {{(OutDataW-PosW-KeyW-PidW-HandleW){1'b0}}, res_pos_q,
                       res_ent_q};
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    item_q     <= item_d;
    idx_q      <= idx_d;
    res_stat_q <= res_stat_d;
    res_ent_q  <= res_ent_d;
    res_pos_q  <= res_pos_d;
    m_data_q   <= m_data_d;
    m_user_q   <= m_user_d;
  end

  fqkr_slot_mem #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_slots (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .probe_i (item_q),
    .rdata_o (rdata),
    .hit_o   (cmp_hit)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // occupancy never exceeds the queue depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count above depth");

  // an insert into a queue with room grows it by one
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_INSERT &&
     cnt_q != CW'(DEPTH)) |=> (cnt_q == $past(cnt_q) + {{(CW-1){1'b0}}, 1'b1}))
    else $error("insert did not grow the queue");

  // scan and shift pointers stay inside the occupied slots
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_CMP || state_q == S_SH_RD ||
     state_q == S_SH_WR) |-> (idx_q < cnt_q))
    else $error("slot index outside queue");

  // a finished result is handed to the output register when it frees
  a_fin_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=> (m_axis_tvalid && state_q == S_IDLE))
    else $error("result not delivered");

  // a removal never leaves the state machine with an empty queue mid-scan
  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (cnt_q != '0))
    else $error("scan on empty queue");

endmodule

`default_nettype wire
